// ----- design/bitmap_slot_allocator_assert.svh -----
// Assertion macros shared by the allocator modules.
`ifndef BITMAP_SLOT_ALLOCATOR_ASSERT_SVH
`define BITMAP_SLOT_ALLOCATOR_ASSERT_SVH
`ifndef SYNTHESIS
`define BSA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("allocator check failed");
`define BSA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("allocator check failed");
`else
`define BSA_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define BSA_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- design/bsa_pkg.sv -----
// Shared types and constants of the bitmap slot allocator.
package bsa_pkg;

    localparam int NUM_SLOTS_DEF = 256;
    localparam int MAX_BATCH_DEF = 64;

    // free map is stored as words of WORD_W slot bits
    localparam int WORD_W  = 16;
    localparam int WORD_LW = 4;

    localparam int OPC_W = 2;
    localparam int SLT_W = 8;
    localparam int CNT_W = 7;
    localparam int RUN_W = 6;

    localparam logic [OPC_W-1:0] OP_FIND_FIRST = 2'd0;
    localparam logic [OPC_W-1:0] OP_FIND_N     = 2'd1;
    localparam logic [OPC_W-1:0] OP_MARK_USED  = 2'd2;
    localparam logic [OPC_W-1:0] OP_MARK_FREE  = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MARK,
        ST_FETCH,
        ST_SCAN,
        ST_NONE
    } state_t;

    typedef struct packed {
        logic             found;
        logic [SLT_W-1:0] slot_id;
        logic [RUN_W-1:0] run_index;
        logic             last;
    } res_t;

endpackage

// ----- design/bsa_map_ram.sv -----
// Free-map word memory with registered read and per-word valid bits.
`include "bitmap_slot_allocator_assert.svh"
module bsa_map_ram
    import bsa_pkg::*;
#(
    parameter int NUM_SLOTS = NUM_SLOTS_DEF,
    localparam int NUM_WORDS = (NUM_SLOTS + WORD_W - 1) / WORD_W,
    localparam int ADDR_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 rd_en,
    input  logic [ADDR_W-1:0]    rd_addr,
    output logic [WORD_W-1:0]    rd_data,
    input  logic                 wr_en,
    input  logic [ADDR_W-1:0]    wr_addr,
    input  logic [WORD_W-1:0]    wr_data
);

    logic [WORD_W-1:0]    mem [NUM_WORDS];
    logic [NUM_WORDS-1:0] vld_reg;
    logic [WORD_W-1:0]    data_reg;
    logic                 dvld_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            data_reg <= mem[rd_addr];
        end
    end

    // a word never written reads as all free
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            dvld_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                dvld_reg <= vld_reg[rd_addr];
            end
        end
    end

    assign rd_data = dvld_reg ? data_reg : {WORD_W{1'b1}};

endmodule

// ----- design/bsa_out_reg.sv -----
// Output register of the result channel.
module bsa_out_reg
    import bsa_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  res_t res,
    output logic can_load,
    output logic out_valid,
    input  logic out_stall,
    output res_t out_res
);

    logic valid_reg;
    logic valid_next;
    res_t res_reg;

    assign can_load   = !valid_reg || !out_stall;
    assign valid_next = push || (valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            res_reg <= res;
        end
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

endmodule

// ----- design/bsa_ctrl.sv -----
// Request sequencer: map read-modify-write and word-by-word free scan.
`include "bitmap_slot_allocator_assert.svh"
module bsa_ctrl
    import bsa_pkg::*;
#(
    parameter int NUM_SLOTS = NUM_SLOTS_DEF,
    parameter int MAX_BATCH = MAX_BATCH_DEF,
    localparam int NUM_WORDS = (NUM_SLOTS + WORD_W - 1) / WORD_W,
    localparam int ADDR_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [OPC_W-1:0]     opcode,
    input  logic [SLT_W-1:0]     slot,
    input  logic [CNT_W-1:0]     request_count,
    output logic                 rd_en,
    output logic [ADDR_W-1:0]    rd_addr,
    input  logic [WORD_W-1:0]    rd_data,
    output logic                 wr_en,
    output logic [ADDR_W-1:0]    wr_addr,
    output logic [WORD_W-1:0]    wr_data,
    output logic                 push,
    output res_t                 res,
    input  logic                 can_load
);

    state_t             state_reg, state_next;
    logic               set_reg, set_next;
    logic [SLT_W-1:0]   slot_reg, slot_next;
    logic [CNT_W-1:0]   want_reg, want_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [ADDR_W-1:0]  word_reg, word_next;
    logic [WORD_W-1:0]  cur_reg, cur_next;
    logic               pend_reg, pend_next;
    logic [SLT_W-1:0]   pslot_reg, pslot_next;

    logic [SLT_W-1:0]   slot_m;
    logic [WORD_LW-1:0] low_pos;
    logic               cur_has;
    logic [WORD_W-1:0]  cur_clr;
    logic [WORD_W-1:0]  word_mask;
    logic [WORD_W-1:0]  bit_sel;
    logic               count_done;
    logic               last_word;
    logic               accept;
    logic [CNT_W-1:0]   want_sat;

    // out-of-range slots fold to slot 0
    assign slot_m = ({24'd0, slot} >= 32'(NUM_SLOTS)) ? '0 : slot;
    assign accept = in_valid && !in_stall;
    assign want_sat = (request_count > CNT_W'(MAX_BATCH)) ? CNT_W'(MAX_BATCH)
                                                           : request_count;

    always_comb
    begin
        low_pos = '0;
        for (int i = WORD_W - 1; i >= 0; i--)
        begin
            if (cur_reg[i])
            begin
                low_pos = WORD_LW'(i);
            end
        end
    end

    // bits past the last slot in the final word never count as free
    always_comb
    begin
        for (int b = 0; b < WORD_W; b++)
        begin
            word_mask[b] = (32'({word_reg, WORD_LW'(b)}) < 32'(NUM_SLOTS));
        end
    end

    assign cur_has    = |cur_reg;
    assign cur_clr    = cur_reg & (cur_reg - WORD_W'(1));
    assign count_done = pend_reg && (cnt_reg == want_reg);
    assign last_word  = (word_reg == ADDR_W'(NUM_WORDS - 1));
    assign bit_sel    = WORD_W'(1) << slot_reg[WORD_LW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        set_reg   <= set_next;
        slot_reg  <= slot_next;
        want_reg  <= want_next;
        cnt_reg   <= cnt_next;
        word_reg  <= word_next;
        cur_reg   <= cur_next;
        pslot_reg <= pslot_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (opcode == OP_MARK_USED || opcode == OP_MARK_FREE)
                    begin
                        state_next = ST_MARK;
                    end
                    else if (opcode == OP_FIND_N && request_count == '0)
                    begin
                        state_next = ST_NONE;
                    end
                    else
                    begin
                        state_next = ST_FETCH;
                    end
                end
            end
            ST_MARK, ST_NONE:
            begin
                if (can_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_FETCH:
            begin
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                priority if (count_done)
                begin
                    if (can_load)
                    begin
                        state_next = ST_IDLE;
                    end
                end
                else if (cur_has)
                begin
                    state_next = ST_SCAN;
                end
                else if (last_word)
                begin
                    if (can_load)
                    begin
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    state_next = ST_FETCH;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        in_stall   = 1'b1;
        rd_en      = 1'b0;
        rd_addr    = word_reg;
        wr_en      = 1'b0;
        wr_addr    = ADDR_W'(slot_reg >> WORD_LW);
        wr_data    = set_reg ? (rd_data | bit_sel) : (rd_data & ~bit_sel);
        push       = 1'b0;
        res        = '{found: 1'b0, slot_id: '0, run_index: '0, last: 1'b1};
        set_next   = set_reg;
        slot_next  = slot_reg;
        want_next  = want_reg;
        cnt_next   = cnt_reg;
        word_next  = word_reg;
        cur_next   = cur_reg;
        pend_next  = pend_reg;
        pslot_next = pslot_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall   = 1'b0;
                set_next   = (opcode == OP_MARK_FREE);
                slot_next  = slot_m;
                want_next  = (opcode == OP_FIND_FIRST) ? CNT_W'(1) : want_sat;
                cnt_next   = '0;
                word_next  = '0;
                pend_next  = 1'b0;
                if (accept)
                begin
                    rd_en = (opcode != OP_FIND_N) || (request_count != '0);
                    if (opcode == OP_MARK_USED || opcode == OP_MARK_FREE)
                    begin
                        rd_addr = ADDR_W'(slot_m >> WORD_LW);
                    end
                    else
                    begin
                        rd_addr = '0;
                    end
                end
            end
            ST_MARK:
            begin
                if (can_load)
                begin
                    wr_en = 1'b1;
                    push  = 1'b1;
                    res   = '{found: 1'b0, slot_id: slot_reg, run_index: '0, last: 1'b1};
                end
            end
            ST_NONE:
            begin
                push = can_load;
            end
            ST_FETCH:
            begin
                cur_next = rd_data & word_mask;
            end
            ST_SCAN:
            begin
                priority if (count_done)
                begin
                    push = can_load;
                    res  = '{found: 1'b1, slot_id: pslot_reg,
                             run_index: RUN_W'(cnt_reg - CNT_W'(1)), last: 1'b1};
                end
                else if (cur_has)
                begin
                    // hold one found slot back until we know whether it is the last
                    res = '{found: 1'b1, slot_id: pslot_reg,
                            run_index: RUN_W'(cnt_reg - CNT_W'(1)), last: 1'b0};
                    if (!pend_reg || can_load)
                    begin
                        push       = pend_reg;
                        cur_next   = cur_clr;
                        pend_next  = 1'b1;
                        pslot_next = SLT_W'({word_reg, low_pos});
                        cnt_next   = cnt_reg + CNT_W'(1);
                    end
                end
                else if (last_word)
                begin
                    push = can_load;
                    if (pend_reg)
                    begin
                        res = '{found: 1'b1, slot_id: pslot_reg,
                                run_index: RUN_W'(cnt_reg - CNT_W'(1)), last: 1'b1};
                    end
                end
                else
                begin
                    rd_en     = 1'b1;
                    rd_addr   = word_reg + ADDR_W'(1);
                    word_next = word_reg + ADDR_W'(1);
                end
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    `BSA_ASSERT_IMP(a_push_room, clk, rst_n, push, can_load)
    `BSA_ASSERT_IMP(a_rw_apart, clk, rst_n, wr_en, !rd_en)
    `BSA_ASSERT_NXT(a_last_frees, clk, rst_n, push && res.last, !in_stall)
    `BSA_ASSERT_NXT(a_write_acks, clk, rst_n, wr_en, !in_stall)

endmodule

// ----- design/bitmap_slot_allocator.sv -----
// Top level of the bitmap free-slot allocator.
//
//  channel | valid     | stall     | payload
//  --------+-----------+-----------+------------------------------------
//  request | in_valid  | in_stall  | opcode, slot, request_count
//  result  | out_valid | out_stall | found, slot_id, run_index, last
//
// The free map lives in a word memory (16 slots per word, registered read).
// Mark: read the word, then write it back with the ack.
// Find: each word is fetched, masked and scanned for free slots, which are sent
//   as results; one request is worked at a time.
// Reset marks every slot free at once through per-word valid bits.
// A stalled result channel holds the sequencer; in_stall stays high until
//   the last result of a request has been loaded into the output register.
module bitmap_slot_allocator
    import bsa_pkg::*;
#(
    parameter int NUM_SLOTS = NUM_SLOTS_DEF,
    parameter int MAX_BATCH = MAX_BATCH_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [OPC_W-1:0]  opcode,
    input  logic [SLT_W-1:0]  slot,
    input  logic [CNT_W-1:0]  request_count,
    output logic              out_valid,
    input  logic              out_stall,
    output logic              found,
    output logic [SLT_W-1:0]  slot_id,
    output logic [RUN_W-1:0]  run_index,
    output logic              last
);

    localparam int NUM_WORDS = (NUM_SLOTS + WORD_W - 1) / WORD_W;
    localparam int ADDR_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;

    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [WORD_W-1:0] rd_data;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [WORD_W-1:0] wr_data;
    logic              push;
    logic              can_load;
    res_t              res;
    res_t              out_res;

    bsa_map_ram #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    // sequencer: one request at a time, at most one result per cycle
    bsa_ctrl #(
        .NUM_SLOTS (NUM_SLOTS),
        .MAX_BATCH (MAX_BATCH)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .opcode        (opcode),
        .slot          (slot),
        .request_count (request_count),
        .rd_en         (rd_en),
        .rd_addr       (rd_addr),
        .rd_data       (rd_data),
        .wr_en         (wr_en),
        .wr_addr       (wr_addr),
        .wr_data       (wr_data),
        .push          (push),
        .res           (res),
        .can_load      (can_load)
    );

    // output register parts the result channel from the scan
    bsa_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .res       (res),
        .can_load  (can_load),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_res   (out_res)
    );

    assign found     = out_res.found;
    assign slot_id   = out_res.slot_id;
    assign run_index = out_res.run_index;
    assign last      = out_res.last;

endmodule
